// ===== rtl/qslerp_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion slerp package
// Transaction types, fixed latencies and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qslerp_pkg;

  typedef struct packed {
    logic signed [15:0] first_w;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_w;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic        [14:0] fraction;
  } req_t;

  typedef struct packed {
    logic signed [15:0] blend_w;
    logic signed [15:0] blend_x;
    logic signed [15:0] blend_y;
    logic signed [15:0] blend_z;
    logic               linear_used;
  } rsp_t;

  localparam int CW       = 34;  // CORDIC datapath width, Q.30
  localparam int SQ_W     = 61;  // radicand width
  localparam int SQRT_LAT = 31;
  localparam int DIV_LAT  = 35;
  localparam logic [14:0] THR_RESET = 15'd16383;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CW-1:0] r;
    unique case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// Quaternion slerp
// Spherical linear interpolation of two Q2.14 quaternions, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction is taken every clock and busy is low except in reset. Each
// result appears on result with done high for one cycle; the latency is set
// by the 31-stage square root, two CORDIC pipelines of one stage per
// iteration and the 35-stage scale divider. The receiver cannot stall the
// block, so done must be taken in the cycle it is shown. cfg_wr_data is
// written to the near-parallel threshold whenever cfg_wr_en is high and rst
// is low; write it only while no transaction is in flight.
module quaternion_slerp import qslerp_pkg::*; #(
  parameter int FRAC_BITS    = 14,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  output logic        done,
  output rsp_t        result
);

  localparam int TW  = FRAC_BITS + 1;
  localparam int TIW = (TW > 15) ? TW : 15;
  localparam int NST = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam logic [TIW-1:0] ONE_I  = TIW'(1) << FRAC_BITS;
  localparam logic [TW-1:0]  ONE    = TW'(1) << FRAC_BITS;
  localparam logic [32:0]    ONE_D  = 33'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] ST_MIN = CW'(1) << (30 - FRAC_BITS);

  typedef struct packed {
    logic [3:0][16:0] a;
    logic [3:0][15:0] b;
    logic [TW-1:0]    t;
    logic             lin;
  } ctx_t;

  logic [14:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  assign busy = rst;

  // stage 1: operands and component products
  logic signed [15:0] fa [4];
  logic signed [15:0] sb [4];
  logic [TIW-1:0]     t_ext;

  assign fa[0] = request.first_w;
  assign fa[1] = request.first_x;
  assign fa[2] = request.first_y;
  assign fa[3] = request.first_z;
  assign sb[0] = request.second_w;
  assign sb[1] = request.second_x;
  assign sb[2] = request.second_y;
  assign sb[3] = request.second_z;
  assign t_ext = TIW'(request.fraction);

  logic               v1;
  logic signed [15:0] a1 [4];
  logic signed [15:0] b1 [4];
  logic signed [31:0] p1 [4];
  logic [TW-1:0]      t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      a1[k] <= fa[k];
      b1[k] <= sb[k];
      p1[k] <= fa[k] * sb[k];
    end
    t1 <= (t_ext > ONE_I) ? ONE : TW'(t_ext);
  end

  // stage 2: sign fold, threshold, clamp
  logic signed [33:0] dotraw;
  logic [33:0]        magw;
  logic [32:0]        dot;
  logic [32:0]        cfull;
  logic               dneg;

  assign dotraw = 34'(p1[0]) + 34'(p1[1]) + 34'(p1[2]) + 34'(p1[3]);
  assign dneg   = dotraw[33];
  assign magw   = dneg ? -dotraw : dotraw;
  assign dot    = magw[32:0] >> FRAC_BITS;
  assign cfull  = (dot > ONE_D) ? ONE_D : dot;

  logic        v2;
  ctx_t        ctx2;
  logic [30:0] cq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      ctx2.a[k] <= dneg ? -17'(a1[k]) : 17'(a1[k]);
      ctx2.b[k] <= b1[k];
    end
    ctx2.t   <= t1;
    ctx2.lin <= dot >= 33'(thr);
    cq2      <= 31'(cfull[TW-1:0]) << (30 - FRAC_BITS);
  end

  // stages 3 and 4: radicand 2^60 - C^2
  logic        v3, v4;
  ctx_t        ctx3, ctx4;
  logic [30:0] cq3, cq4;
  logic [61:0] csq3;
  logic [SQ_W-1:0] rad4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    ctx3 <= ctx2;
    cq3  <= cq2;
    csq3 <= cq2 * cq2;
    ctx4 <= ctx3;
    cq4  <= cq3;
    rad4 <= (SQ_W'(1) << 60) - csq3[SQ_W-1:0];
  end

  logic [30:0] sq;

  qslerp_isqrt u_isqrt (
    .clk      (clk),
    .radicand (rad4),
    .root     (sq)
  );

  logic        vs;
  ctx_t        ctx_s;
  logic [30:0] cq_s;

  qslerp_delay #(.W($bits(ctx_t) + 31), .DEPTH(SQRT_LAT)) u_dly_sqrt (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (v4),
    .d       ({ctx4, cq4}),
    .vld_out (vs),
    .q       ({ctx_s, cq_s})
  );

  // theta = acos(C)
  logic signed [CW-1:0] theta, vx_unused, vy_unused;

  qslerp_cordic #(.VECTOR(1'b1), .NST(NST)) u_acos (
    .clk   (clk),
    .x_in  (CW'(cq_s)),
    .y_in  (CW'(sq)),
    .z_in  ('0),
    .x_out (vx_unused),
    .y_out (vy_unused),
    .z_out (theta)
  );

  logic vt;
  ctx_t ctx_t_d;

  qslerp_delay #(.W($bits(ctx_t)), .DEPTH(NST)) u_dly_acos (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vs),
    .d       (ctx_s),
    .vld_out (vt),
    .q       (ctx_t_d)
  );

  // stage A: split angles
  logic [30:0]       th;
  logic [TW-1:0]     omt;
  logic [TW+30:0]    pa0, pa1;

  assign th  = theta[CW-1] ? '0 : theta[30:0];
  assign omt = ONE - ctx_t_d.t;
  assign pa0 = omt * th;
  assign pa1 = ctx_t_d.t * th;

  logic                 va;
  ctx_t                 ctx_a;
  logic signed [CW-1:0] theta_a, ang0, ang1;
  logic [30:0]          th_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= vt;
    end
  end

  always_ff @(posedge clk) begin
    ctx_a   <= ctx_t_d;
    theta_a <= theta;
    th_a    <= th;
    ang0    <= CW'(pa0 >> FRAC_BITS);
    ang1    <= CW'(pa1 >> FRAC_BITS);
  end

  // sines; the CORDIC gain cancels in the ratios
  logic signed [CW-1:0] st, sn0, sn1;
  logic signed [CW-1:0] rx0, rz0, rx1, rz1, rx2, rz2;

  qslerp_cordic #(.VECTOR(1'b0), .NST(NST)) u_sin_th (
    .clk (clk), .x_in (CW'(1) << 30), .y_in ('0), .z_in (theta_a),
    .x_out (rx0), .y_out (st), .z_out (rz0)
  );

  qslerp_cordic #(.VECTOR(1'b0), .NST(NST)) u_sin_a0 (
    .clk (clk), .x_in (CW'(1) << 30), .y_in ('0), .z_in (ang0),
    .x_out (rx1), .y_out (sn0), .z_out (rz1)
  );

  qslerp_cordic #(.VECTOR(1'b0), .NST(NST)) u_sin_a1 (
    .clk (clk), .x_in (CW'(1) << 30), .y_in ('0), .z_in (ang1),
    .x_out (rx2), .y_out (sn1), .z_out (rz2)
  );

  logic vn;
  ctx_t ctx_n, ctx_n2;

  qslerp_delay #(.W($bits(ctx_t)), .DEPTH(NST)) u_dly_sin (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (va),
    .d       (ctx_a),
    .vld_out (vn),
    .q       (ctx_n)
  );

  // vanishing sine falls back to the linear blend
  always_comb begin
    ctx_n2     = ctx_n;
    ctx_n2.lin = ctx_n.lin || (st < ST_MIN);
  end

  logic signed [CW-1:0] sc0, sc1;

  qslerp_div u_div0 (.clk (clk), .num (sn0), .den (st), .quo (sc0));
  qslerp_div u_div1 (.clk (clk), .num (sn1), .den (st), .quo (sc1));

  logic vd;
  ctx_t ctx_d;

  qslerp_delay #(.W($bits(ctx_t)), .DEPTH(DIV_LAT)) u_dly_div (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vn),
    .d       (ctx_n2),
    .vld_out (vd),
    .q       (ctx_d)
  );

  // final stage 1: weighted products
  logic signed [CW-1:0] m0, m1;

  assign m0 = ctx_d.lin ? $signed(CW'(ONE - ctx_d.t)) : sc0;
  assign m1 = ctx_d.lin ? $signed(CW'(ctx_d.t)) : sc1;

  logic               vf;
  logic               lin_f;
  logic signed [50:0] pr0 [4];
  logic signed [50:0] pr1 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else begin
      vf <= vd;
    end
  end

  always_ff @(posedge clk) begin
    lin_f <= ctx_d.lin;
    for (int k = 0; k < 4; k++) begin
      pr0[k] <= m0 * $signed(ctx_d.a[k]);
      pr1[k] <= m1 * $signed({ctx_d.b[k][15], ctx_d.b[k]});
    end
  end

  // final stage 2: round, shift, saturate
  logic signed [51:0] rsum [4];
  logic signed [51:0] rsh  [4];
  logic signed [15:0] sat  [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rsum[k] = 52'(pr0[k]) + 52'(pr1[k])
              + (lin_f ? (52'(1) << (FRAC_BITS - 1)) : (52'(1) << 29));
      rsh[k]  = lin_f ? (rsum[k] >>> FRAC_BITS) : (rsum[k] >>> 30);
      if (rsh[k] > 52'sd32767) begin
        sat[k] = 16'sh7fff;
      end else if (rsh[k] < -52'sd32768) begin
        sat[k] = 16'sh8000;
      end else begin
        sat[k] = rsh[k][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vf;
    end
  end

  always_ff @(posedge clk) begin
    result.blend_w     <= sat[0];
    result.blend_x     <= sat[1];
    result.blend_y     <= sat[2];
    result.blend_z     <= sat[3];
    result.linear_used <= lin_f;
  end

`ifndef NO_ASSERTIONS
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    vs |-> (sq <= 31'h4000_0000))
    else $error("square root above one");

  a_split_angles: assert property (@(posedge clk) disable iff (rst)
    va |-> (33'(ang0) + 33'(ang1) <= 33'(th_a)))
    else $error("split angles exceed theta");

  a_reset_flush: assert property (@(posedge clk)
    $fell(rst) |-> !done)
    else $error("result strobe straight after reset");
`endif

endmodule

// ===== rtl/qslerp_delay.sv =====
// ----------------------------------------------------------------------------
// Quaternion slerp delay line
// Carries side data and the valid bit alongside a fixed-latency unit.
// ----------------------------------------------------------------------------
module qslerp_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         vld_in,
  input  logic [W-1:0] d,
  output logic         vld_out,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      line[i] <= line[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (DEPTH == 1) begin
      vld <= DEPTH'(vld_in);
    end else begin
      vld <= {vld[DEPTH-2:0], vld_in};
    end
  end

  assign q       = line[DEPTH-1];
  assign vld_out = vld[DEPTH-1];

endmodule

// ===== rtl/qslerp_isqrt.sv =====
// ----------------------------------------------------------------------------
// Quaternion slerp square root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qslerp_isqrt import qslerp_pkg::*; (
  input  logic            clk,
  input  logic [SQ_W-1:0] radicand,
  output logic [30:0]     root
);

  logic [SQ_W-1:0] rv [SQRT_LAT+1];
  logic [SQ_W-1:0] rr [SQRT_LAT+1];

  assign rv[0] = radicand;
  assign rr[0] = '0;

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] trial;
    assign bitv  = SQ_W'(1) << (60 - 2*k);
    assign trial = rr[k] + bitv;
    always_ff @(posedge clk) begin
      if (rv[k] >= trial) begin
        rv[k+1] <= rv[k] - trial;
        rr[k+1] <= (rr[k] >> 1) + bitv;
      end else begin
        rv[k+1] <= rv[k];
        rr[k+1] <= rr[k] >> 1;
      end
    end
  end

  assign root = rr[SQRT_LAT][30:0];

endmodule

// ===== rtl/qslerp_cordic.sv =====
// ----------------------------------------------------------------------------
// Quaternion slerp CORDIC
// Pipelined CORDIC, one micro-rotation per stage; vectoring or rotation.
// ----------------------------------------------------------------------------
module qslerp_cordic import qslerp_pkg::*; #(
  parameter bit VECTOR = 1'b0,
  parameter int NST    = 16
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] z_in,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [CW-1:0] z_out
);

  logic signed [CW-1:0] x [NST+1];
  logic signed [CW-1:0] y [NST+1];
  logic signed [CW-1:0] z [NST+1];

  assign x[0] = x_in;
  assign y[0] = y_in;
  assign z[0] = z_in;

  for (genvar i = 0; i < NST; i++) begin : g_stage
    logic signed [CW-1:0] dx, dy, at;
    logic                 up;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    assign at = atan_q30(5'(i));
    // vectoring drives y to zero, rotation drives z to zero
    assign up = VECTOR ? (y[i] > 0) : (z[i] < 0);
    always_ff @(posedge clk) begin
      if (up) begin
        x[i+1] <= x[i] + dx;
        y[i+1] <= y[i] - dy;
        z[i+1] <= VECTOR ? z[i] + at : z[i] + at;
      end else begin
        x[i+1] <= x[i] - dx;
        y[i+1] <= y[i] + dy;
        z[i+1] <= z[i] - at;
      end
    end
  end

  assign x_out = x[NST];
  assign y_out = y[NST];
  assign z_out = z[NST];

endmodule

// ===== rtl/qslerp_div.sv =====
// ----------------------------------------------------------------------------
// Quaternion slerp scale divider
// Pipelined restoring divider: num * 2^30 / den, truncated, clamped to +-4.0.
// ----------------------------------------------------------------------------
module qslerp_div import qslerp_pkg::*; (
  input  logic                 clk,
  input  logic signed [CW-1:0] num,
  input  logic signed [CW-1:0] den,
  output logic signed [CW-1:0] quo
);

  localparam int QB = 33;
  localparam logic [QB-1:0] LIM = QB'(1) << 32;

  logic [QB-1:0] rem  [QB+1];
  logic [QB-1:0] pend [QB+1];
  logic [QB-1:0] q    [QB+1];
  logic [QB-1:0] dv   [QB+1];
  logic          neg  [QB+1];
  logic          ovf  [QB+1];

  logic [QB-1:0] mag;

  assign mag = num[CW-1] ? QB'(-num) : QB'(num);

  always_ff @(posedge clk) begin
    neg[0]  <= num[CW-1];
    dv[0]   <= den[QB-1:0];
    ovf[0]  <= {3'b000, mag} >= {den[QB-1:0], 3'b000};
    rem[0]  <= mag >> 3;
    pend[0] <= {mag[2:0], 30'd0};
    q[0]    <= '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [QB:0] r2;
    logic        ge;
    assign r2 = {rem[k], pend[k][QB-1]};
    assign ge = r2 >= {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      rem[k+1]  <= ge ? QB'(r2 - {1'b0, dv[k]}) : QB'(r2);
      pend[k+1] <= pend[k] << 1;
      q[k+1]    <= {q[k][QB-2:0], ge};
      dv[k+1]   <= dv[k];
      neg[k+1]  <= neg[k];
      ovf[k+1]  <= ovf[k];
    end
  end

  logic [QB-1:0] qm;
  assign qm = (ovf[QB] || q[QB] > LIM) ? LIM : q[QB];

  always_ff @(posedge clk) begin
    quo <= neg[QB] ? -$signed(CW'(qm)) : $signed(CW'(qm));
  end

endmodule
